@@ rtl/dq_pkg.sv @@
// Shared types and codes for the double-ended queue.
// Used by dq_cell and double_ended_queue_unit; depends on nothing.
package dq_pkg;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_DUMP       = 3'd4
  } mode_e_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  // What every cell of the chain does; the same operation goes to all cells.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] value;
  } cell_ctrl_t;

endpackage

@@ rtl/double_ended_queue_unit.sv @@
// Double-ended queue of signed 32-bit values, built as a chain of cells.
// Depends on dq_pkg and dq_cell.
//
// The queue holds up to DEPTH values in a row of cells, with the front
// always in cell 0. A push at either end, a pop at either end and an
// invalid request each give one result item, and such requests are
// accepted back to back while the result register drains. A dump of n
// stored values gives n items, front first, with last set on the final
// one; the chain rotates one place per item, and the dump holds off new
// requests until its final item has been produced. Pops and dumps of an
// empty queue report empty; a push into a full queue is dropped and
// reports full. No clearing pass is needed after reset.
module double_ended_queue_unit
  import dq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [2:0]         mode,
  input  logic signed [31:0] value,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [1:0]         status,
  output logic signed [31:0] value_res,
  output logic               last
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  state_t             state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      remain, remain_next;
  logic               res_valid_next;
  status_t            status_reg, status_next;
  logic signed [31:0] value_res_next;
  logic               last_next;
  cell_ctrl_t         ctrl;
  logic               out_free;
  logic               accept;
  logic signed [31:0] back_data;

  logic signed [31:0] cell_data [DEPTH];
  logic signed [31:0] cell_tail [DEPTH];

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [31:0] left_in;
      logic signed [31:0] right_in;
      if (g == 0) begin : g_first
        assign left_in = value;
      end else begin : g_mid_l
        assign left_in = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_final
        assign right_in = cell_data[g];
      end else begin : g_mid_r
        assign right_in = cell_data[g+1];
      end
      dq_cell #(
        .CW  (CW),
        .IDX (g)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .count      (count),
        .from_left  (left_in),
        .from_right (right_in),
        .head       (cell_data[0]),
        .data       (cell_data[g]),
        .tail_data  (cell_tail[g])
      );
    end
  endgenerate

  // Only the back cell drives its word; all others give zero, so an OR picks it out.
  always_comb begin
    back_data = 32'sd0;
    for (int i = 0; i < DEPTH; i++) begin
      back_data = back_data | cell_tail[i];
    end
  end

  assign out_free  = !res_valid || res_ready;
  assign req_ready = (state == S_IDLE) && out_free;
  assign accept    = req_valid && req_ready;
  assign status    = status_reg;

  always_comb begin
    state_next     = state;
    count_next     = count;
    remain_next    = remain;
    res_valid_next = res_valid && !res_ready;
    status_next    = status_reg;
    value_res_next = value_res;
    last_next      = last;
    ctrl.op        = OP_HOLD;
    ctrl.value     = value;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_valid_next = 1'b1;
          status_next    = ST_OK;
          value_res_next = 32'sd0;
          last_next      = 1'b1;
          unique case (mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              if (count == CW'(DEPTH)) begin
                status_next = ST_FULL;
              end else begin
                ctrl.op    = (mode == MODE_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                count_next = count + CW'(1);
              end
            end
            MODE_POP_FRONT: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                ctrl.op        = OP_POP_FRONT;
                value_res_next = cell_data[0];
                count_next     = count - CW'(1);
              end
            end
            MODE_POP_BACK: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                value_res_next = back_data;
                count_next     = count - CW'(1);
              end
            end
            MODE_DUMP: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                // First item goes out now; the rest follow one per cycle while the output side accepts them.
                ctrl.op        = OP_ROTATE;
                value_res_next = cell_data[0];
                last_next      = (count == CW'(1));
                remain_next    = count - CW'(1);
                if (count != CW'(1)) begin
                  state_next = S_DUMP;
                end
              end
            end
            default: begin
              status_next = ST_INVALID;
            end
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          ctrl.op        = OP_ROTATE;
          res_valid_next = 1'b1;
          status_next    = ST_OK;
          value_res_next = cell_data[0];
          last_next      = (remain == CW'(1));
          remain_next    = remain - CW'(1);
          if (remain == CW'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      remain    <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remain    <= remain_next;
      res_valid <= res_valid_next;
    end
    status_reg <= status_next;
    value_res  <= value_res_next;
    last       <= last_next;
  end

endmodule

@@ rtl/dq_cell.sv @@
// One storage cell of the queue chain: holds one element and moves it
// to or from its neighbours as the broadcast operation says. Uses dq_pkg.
module dq_cell
  import dq_pkg::*;
#(
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [CW-1:0]         count,
  input  logic signed [31:0]    from_left,
  input  logic signed [31:0]    from_right,
  input  logic signed [31:0]    head,
  output logic signed [31:0]    data,
  output logic signed [31:0]    tail_data
);

  logic signed [31:0] data_next;
  logic               is_tail;

  // The back element sits in the cell just below the fill count.
  assign is_tail   = (count == CW'(IDX + 1));
  assign tail_data = is_tail ? data : 32'sd0;

  always_comb begin
    data_next = data;
    unique case (ctrl.op)
      OP_HOLD:       data_next = data;
      OP_PUSH_FRONT: data_next = from_left;
      OP_PUSH_BACK: begin
        if (count == CW'(IDX)) begin
          data_next = ctrl.value;
        end
      end
      OP_POP_FRONT:  data_next = from_right;
      OP_ROTATE: begin
        // The front element wraps round into the back cell.
        if (is_tail) begin
          data_next = head;
        end else begin
          data_next = from_right;
        end
      end
      default:       data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
